>>> rtl/byte_key_mixing_hash_defines.svh
// Assertion macros for the byte key mixing hash.
`ifndef BYTE_KEY_MIXING_HASH_DEFINES_SVH
`define BYTE_KEY_MIXING_HASH_DEFINES_SVH

// Checked while out of reset.
`define BKMH_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked during reset as well.
`define BKMH_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/bkmh_pkg.sv
// Shared types, constants and helper functions for the byte key mixing hash.
package bkmh_pkg;

  localparam int unsigned FoldSteps = 9;

  localparam logic [63:0] LenMul     = 64'h0000_0185_2103_1531;
  localparam logic [31:0] LenMulLo   = LenMul[31:0];
  localparam logic [31:0] LenMulHi   = LenMul[63:32];
  localparam logic [63:0] InitXor    = 64'h0000_1e20_93c8_9a0b;
  localparam logic [16:0] SeedMul    = 17'h13467;
  localparam logic [31:0] TailMul    = 32'h0305_0901;
  localparam logic [7:0]  ByteXorLsb = 8'h11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_NINE,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_LEN_MIX,
    ST_FOLD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic       mul_clr;
    logic       mul_tail;
    logic [1:0] byte_idx;
    logic       add_en;
    logic       nine_en;
    logic       len_lo_en;
    logic       len_hi_en;
    logic       len_mix_en;
    logic       fold_en;
    logic [3:0] fold_idx;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  // Per-lane multiplier for a full word.
  function automatic logic [31:0] byte_mul(input logic [1:0] idx);
    logic [31:0] k;
    unique case (idx)
      2'd0: k = 32'h0003_0509;
      2'd1: k = 32'h0900_0301;
      2'd2: k = 32'h0509_0003;
      2'd3: k = 32'h0301_0900;
      default: k = 32'h0003_0509;
    endcase
    return k;
  endfunction

  // One step of the final fold cascade.
  function automatic logic [63:0] fold_step(input logic [63:0] t, input logic [3:0] idx);
    logic [63:0] r;
    unique case (idx)
      4'd0: r = t ^ (t << 16);
      4'd1: r = t + (t >> 3);
      4'd2: r = t ^ (t << 8);
      4'd3: r = t + (t >> 6);
      4'd4: r = t ^ (t << 4);
      4'd5: r = t + (t >> 12);
      4'd6: r = t ^ (t << 2);
      4'd7: r = t + (t >> 11);
      4'd8: r = t ^ (t << 1);
      default: r = t;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/bkmh_ctrl.sv
// Sequencer for the byte key mixing hash: steps the datapath through each word.
module bkmh_ctrl import bkmh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] byte_count_i,
  input  logic       last_word_i,
  output logic       in_stall_o,
  input  status_t    status_i,
  output cmd_t       cmd_o
);

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic [3:0] fold_q, fold_d;
  logic       last_q, last_d;
  logic       full_q, full_d;
  logic [1:0] cnt_q, cnt_d;
  logic       full_in;

  assign full_in    = !last_word_i || (byte_count_i >= 3'd4);
  assign in_stall_o = (state_q != ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    fold_d  = fold_q;
    last_d  = last_q;
    full_d  = full_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d = last_word_i;
          full_d = full_in;
          cnt_d  = byte_count_i[1:0];
          idx_d  = 2'd0;
          if (!full_in && byte_count_i[1:0] == 2'd0) begin
            state_d = ST_LEN_LO;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (full_q) begin
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) state_d = ST_ADD;
        end else begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: state_d = ST_NINE;
      ST_NINE: begin
        if (!full_q && (idx_q + 2'd1) != cnt_q) begin
          idx_d   = idx_q + 2'd1;
          state_d = ST_MUL;
        end else if (last_q) begin
          state_d = ST_LEN_LO;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LEN_LO:  state_d = ST_LEN_HI;
      ST_LEN_HI:  state_d = ST_LEN_MIX;
      ST_LEN_MIX: begin
        fold_d  = 4'd0;
        state_d = ST_FOLD;
      end
      ST_FOLD: begin
        fold_d = fold_q + 4'd1;
        if (fold_q == 4'(FoldSteps - 1)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.byte_idx = idx_q;
    cmd_o.fold_idx = fold_q;
    cmd_o.mul_tail = !full_q;
    cmd_o.mul_clr  = !full_q || (idx_q == 2'd0);
    unique case (state_q)
      ST_IDLE:    cmd_o.load       = in_valid_i;
      ST_MUL:     cmd_o.mul_en     = 1'b1;
      ST_ADD:     cmd_o.add_en     = 1'b1;
      ST_NINE:    cmd_o.nine_en    = 1'b1;
      ST_LEN_LO:  cmd_o.len_lo_en  = 1'b1;
      ST_LEN_HI:  cmd_o.len_hi_en  = 1'b1;
      ST_LEN_MIX: cmd_o.len_mix_en = 1'b1;
      ST_FOLD:    cmd_o.fold_en    = 1'b1;
      ST_OUT:     cmd_o.out_load   = status_i.out_free;
      default:    cmd_o.load       = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= 2'd0;
      fold_q  <= 4'd0;
      last_q  <= 1'b0;
      full_q  <= 1'b0;
      cnt_q   <= 2'd0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      fold_q  <= fold_d;
      last_q  <= last_d;
      full_q  <= full_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

>>> rtl/bkmh_datapath.sv
// Datapath of the byte key mixing hash: chain, accumulator, length and fold registers.
module bkmh_datapath import bkmh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [31:0] hash_seed_i,
  input  logic [31:0] key_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  input  cmd_t        cmd_i,
  output status_t     status_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [31:0] hash_value_o
);

  logic [31:0] seed_q;
  logic        start_q;
  logic [31:0] word_q;
  logic [63:0] chain_q;
  logic [63:0] acc_q;
  logic [31:0] len_q;
  logic [63:0] mix_q, mix_d;
  logic [63:0] lenp_lo_q;
  logic [31:0] lenp_hi_q;
  logic [63:0] fold_q;
  logic        out_valid_q;
  logic [31:0] hash_q;

  logic [2:0]  len_add;
  logic [31:0] len_base;
  logic [7:0]  mul_byte;
  logic [31:0] mul_k;
  logic [39:0] prod;
  logic [63:0] prod_sh;
  logic [63:0] chain_x9;

  assign len_add  = (!last_word_i || byte_count_i >= 3'd4) ? 3'd4 : byte_count_i;
  assign len_base = start_q ? 32'd0 : len_q;

  // shared byte multiplier: lane j uses xor mask 0x11 << j in both modes
  assign mul_byte = word_q[8*cmd_i.byte_idx +: 8] ^ (ByteXorLsb << cmd_i.byte_idx);
  assign mul_k    = cmd_i.mul_tail ? TailMul : byte_mul(cmd_i.byte_idx);
  assign prod     = 40'(mul_byte) * 40'(mul_k);
  assign prod_sh  = cmd_i.mul_tail ? (64'(prod) << {cmd_i.byte_idx, 1'b0}) : 64'(prod);
  assign mix_d    = (cmd_i.mul_clr ? 64'd0 : mix_q) ^ prod_sh;

  assign chain_x9 = chain_q + (chain_q << 3);

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign hash_value_o      = hash_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= 32'd0;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (hash_seed_we_i) seed_q <= hash_seed_i;
      if (cmd_i.out_load) begin
        start_q <= 1'b1;
      end else if (cmd_i.load) begin
        start_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      word_q <= key_word_i;
      len_q  <= len_base + 32'(len_add);
      if (start_q) begin
        chain_q <= 64'(seed_q);
        acc_q   <= (64'(seed_q) * 64'(SeedMul)) ^ InitXor;
      end
    end
    if (cmd_i.mul_en) mix_q <= mix_d;
    if (cmd_i.add_en) chain_q <= chain_q + mix_q;
    if (cmd_i.nine_en) begin
      chain_q <= chain_x9;
      acc_q   <= acc_q ^ chain_x9;
    end
    // length term split into a 32x32 and a narrow high product
    if (cmd_i.len_lo_en) lenp_lo_q <= 64'(len_q) * 64'(LenMulLo);
    if (cmd_i.len_hi_en) lenp_hi_q <= 32'(len_q * LenMulHi);
    if (cmd_i.len_mix_en) fold_q <= acc_q ^ (lenp_lo_q + {lenp_hi_q, 32'd0});
    if (cmd_i.fold_en) fold_q <= fold_step(fold_q, cmd_i.fold_idx);
    if (cmd_i.out_load) hash_q <= fold_q[31:0];
  end

endmodule

>>> rtl/byte_key_mixing_hash.sv
// Top level of the byte key mixing hash: sequencer, datapath and checks.
// The block takes one key word at a time; the input stalls while a word is being worked.
// A non-last word, or a last word of four bytes, runs from acceptance through a load step,
// each of its four bytes in turn on the shared 8x32 byte multiplier, one chain add and one
// times-nine/accumulate step before the next word can be accepted. A short last word with n
// tail bytes runs the load and then multiply, add and times-nine for each byte in turn. A last
// word then runs the length product (low, high, mix), the serial fold cascade and the load of
// the output register, which waits until a pending hash has been taken. The output register
// lets the next key's first word be accepted while the hash still waits to be taken. A seed
// write is used at the start of the next key.
`include "byte_key_mixing_hash_defines.svh"

module byte_key_mixing_hash import bkmh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hash_seed_we_i,
  input  logic [31:0] hash_seed_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] key_word_i,
  input  logic [2:0]  byte_count_i,
  input  logic        last_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  cmd_t    cmd;
  status_t status;

  bkmh_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .byte_count_i (byte_count_i),
    .last_word_i  (last_word_i),
    .in_stall_o   (in_stall_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  bkmh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .hash_seed_we_i (hash_seed_we_i),
    .hash_seed_i    (hash_seed_i),
    .key_word_i     (key_word_i),
    .byte_count_i   (byte_count_i),
    .last_word_i    (last_word_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .hash_value_o   (hash_value_o)
  );

  `BKMH_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o, "no stall after word accepted")
  `BKMH_ASSERT(a_load_only_free, cmd.out_load |-> (!out_valid_o || !out_stall_i), "hash overwrote a pending result")
  `BKMH_ASSERT(a_valid_from_load, $rose(out_valid_o) |-> $past(cmd.out_load), "result valid without a load")
  `BKMH_ASSERT_ALWAYS(a_reset_clears, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule
